/* hw/rtl/pbs_pkg.sv */
// pbs_pkg: shared types and constants for the power button sequencer.
// No dependencies; compile first.

package pbs_pkg;

	localparam int unsigned TPS_W    = 16;   // ticks per second register
	localparam int unsigned SEC_W    = 8;    // seconds registers
	localparam int unsigned SEQ_W    = 24;   // sequence tick counter, seconds * ticks
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned OUT_W    = 32;   // on_time_seconds field
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SECONDS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_TIMEOUT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_TIMEOUT  = 3'd4;

	// Register reset values
	localparam logic [TPS_W-1:0] TPS_RST       = 16'd1000;
	localparam logic [SEC_W-1:0] PRESS_RST     = 8'd1;
	localparam logic [SEC_W-1:0] SHUTDOWN_RST  = 8'd60;
	localparam logic [SEC_W-1:0] FORCE_RST     = 8'd10;
	localparam logic [SEC_W-1:0] POWER_ON_RST  = 8'd60;

	localparam logic [SEQ_W-1:0] PRESS_TICKS_RST = SEQ_W'(1000 * 1);
	localparam logic [SEQ_W-1:0] OFF_TICKS_RST   = SEQ_W'(1000 * 60);
	localparam logic [SEQ_W-1:0] FORCE_TICKS_RST = SEQ_W'(1000 * 10);
	localparam logic [SEQ_W-1:0] ON_TICKS_RST    = SEQ_W'(1000 * 60);

	typedef enum logic [MODE_W-1:0] {
		CMD_NONE   = 3'd0,
		CMD_ON     = 3'd1,
		CMD_OFF    = 3'd2,
		CMD_FORCE  = 3'd3,
		CMD_REBOOT = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PRESS = 2'd1,
		PH_WAIT  = 2'd2,
		PH_FORCE = 2'd3
	} phase_t;

	// Durations in ticks, kept in step with the configuration registers
	typedef struct packed {
		logic [TPS_W-1:0] ticks_per_second;
		logic [SEQ_W-1:0] press_ticks;
		logic [SEQ_W-1:0] off_timeout_ticks;
		logic [SEQ_W-1:0] force_timeout_ticks;
		logic [SEQ_W-1:0] on_timeout_ticks;
	} timing_t;

endpackage

/* hw/rtl/pbs_chan_if.sv */
// Request channels of the power button sequencer: tick items in, results out.
// Depends on pbs_pkg.

interface pbs_item_if;
	logic                          valid;
	logic                          ready;
	logic                          sense_level;
	logic [pbs_pkg::MODE_W-1:0]    mode;

	modport source (output valid, output sense_level, output mode, input ready);
	modport sink   (input valid, input sense_level, input mode, output ready);
endinterface

interface pbs_result_if;
	logic                          valid;
	logic                          ready;
	logic                          relay_drive;
	logic                          machine_on;
	logic                          busy_res;
	logic                          done_res;
	logic                          success;
	logic [pbs_pkg::OUT_W-1:0]     on_time_seconds;

	modport source (output valid, output relay_drive, output machine_on, output busy_res,
		output done_res, output success, output on_time_seconds, input ready);
	modport sink   (input valid, input relay_drive, input machine_on, input busy_res,
		input done_res, input success, input on_time_seconds, output ready);
endinterface

/* hw/rtl/pbs_cfg.sv */
// pbs_cfg: configuration registers and the derived tick durations.
// Depends on pbs_pkg.

module pbs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output pbs_pkg::timing_t                 timing
);

	logic [pbs_pkg::TPS_W-1:0] tps_q, tps_d;
	logic [pbs_pkg::SEC_W-1:0] press_q, press_d;
	logic [pbs_pkg::SEC_W-1:0] off_to_q, off_to_d;
	logic [pbs_pkg::SEC_W-1:0] force_to_q, force_to_d;
	logic [pbs_pkg::SEC_W-1:0] on_to_q, on_to_d;

	logic [pbs_pkg::SEQ_W-1:0] press_ticks_q, off_ticks_q, force_ticks_q, on_ticks_q;

	always_comb begin
		tps_d      = tps_q;
		press_d    = press_q;
		off_to_d   = off_to_q;
		force_to_d = force_to_q;
		on_to_d    = on_to_q;
		if (cfg_we) begin
			unique case (cfg_index)
				pbs_pkg::CFG_TICKS_PER_SECOND: tps_d      = cfg_wdata;
				pbs_pkg::CFG_PRESS_SECONDS:    press_d    = cfg_wdata[pbs_pkg::SEC_W-1:0];
				pbs_pkg::CFG_SHUTDOWN_TIMEOUT: off_to_d   = cfg_wdata[pbs_pkg::SEC_W-1:0];
				pbs_pkg::CFG_FORCE_TIMEOUT:    force_to_d = cfg_wdata[pbs_pkg::SEC_W-1:0];
				pbs_pkg::CFG_POWER_ON_TIMEOUT: on_to_d    = cfg_wdata[pbs_pkg::SEC_W-1:0];
				default: ;
			endcase
		end
	end

	// Products are taken from the next register values so they never lag a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q         <= pbs_pkg::TPS_RST;
			press_q       <= pbs_pkg::PRESS_RST;
			off_to_q      <= pbs_pkg::SHUTDOWN_RST;
			force_to_q    <= pbs_pkg::FORCE_RST;
			on_to_q       <= pbs_pkg::POWER_ON_RST;
			press_ticks_q <= pbs_pkg::PRESS_TICKS_RST;
			off_ticks_q   <= pbs_pkg::OFF_TICKS_RST;
			force_ticks_q <= pbs_pkg::FORCE_TICKS_RST;
			on_ticks_q    <= pbs_pkg::ON_TICKS_RST;
		end else begin
			tps_q         <= tps_d;
			press_q       <= press_d;
			off_to_q      <= off_to_d;
			force_to_q    <= force_to_d;
			on_to_q       <= on_to_d;
			press_ticks_q <= pbs_pkg::SEQ_W'(tps_d) * pbs_pkg::SEQ_W'(press_d);
			off_ticks_q   <= pbs_pkg::SEQ_W'(tps_d) * pbs_pkg::SEQ_W'(off_to_d);
			force_ticks_q <= pbs_pkg::SEQ_W'(tps_d) * pbs_pkg::SEQ_W'(force_to_d);
			on_ticks_q    <= pbs_pkg::SEQ_W'(tps_d) * pbs_pkg::SEQ_W'(on_to_d);
		end
	end

	assign timing.ticks_per_second    = tps_q;
	assign timing.press_ticks         = press_ticks_q;
	assign timing.off_timeout_ticks   = off_ticks_q;
	assign timing.force_timeout_ticks = force_ticks_q;
	assign timing.on_timeout_ticks    = on_ticks_q;

endmodule

/* hw/rtl/power_button_sequencer_top.sv */
// Channel   Dir  Contents                                            Handshake
// item      in   sense_level, mode                                   valid/ready
// result    out  relay_drive, machine_on, busy_res, done_res,        valid/ready
//                success, on_time_seconds
// cfg       in   cfg_we, cfg_index, cfg_wdata                        write enable
//
// One tick request per cycle while the result is not stalled. A request is held in
// the input register and is then evaluated into the result register.
// Sequencer state and counters move only when a request passes into the result
// register. A stalled result holds; the input register still takes one more request.
// Reset returns the registers to their documented values and the phase to idle.
// Depends on pbs_pkg, pbs_chan_if, pbs_cfg.

module power_button_sequencer_top #(
	parameter int unsigned ON_TIME_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pbs_item_if.sink                        item,
	pbs_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [pbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	pbs_pkg::timing_t timing;

	pbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.timing    (timing)
	);

	// Input register
	logic                         valid_s1;
	logic                         sense_s1;
	logic [pbs_pkg::MODE_W-1:0]   mode_s1;
	logic                         advance;
	logic                         in_take;

	// Sequencer state
	pbs_pkg::phase_t              phase_q, phase_d;
	pbs_pkg::cmd_t                cmd_q, cmd_d;
	logic                         reboot_q, reboot_d;
	logic [pbs_pkg::SEQ_W-1:0]    seq_q, seq_d;
	logic [pbs_pkg::TPS_W-1:0]    sub_q, sub_d;
	logic [ON_TIME_BITS-1:0]      on_sec_q, on_sec_d;

	// Result register
	logic                         out_valid_q;
	logic                         relay_q, machine_on_q, busy_q, done_q, succ_q;
	logic [pbs_pkg::OUT_W-1:0]    on_time_q;

	logic                         on;
	logic                         relay_d, done_d, succ_d, chain;
	logic [pbs_pkg::SEQ_W-1:0]    wait_limit;
	logic [pbs_pkg::TPS_W:0]      sub_inc;
	logic [pbs_pkg::OUT_W-1:0]    on_time_sat;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign in_take    = item.valid && item.ready;
	assign on         = !sense_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sense_s1 <= item.sense_level;
			mode_s1  <= item.mode;
		end
	end

	// Next phase; a single tick may run press -> wait -> press -> wait on a reboot
	always_comb begin
		phase_d    = phase_q;
		cmd_d      = cmd_q;
		reboot_d   = reboot_q;
		seq_d      = seq_q;
		relay_d    = 1'b0;
		done_d     = 1'b0;
		succ_d     = 1'b0;
		chain      = 1'b0;
		wait_limit = timing.force_timeout_ticks;

		if (phase_d == pbs_pkg::PH_IDLE && (mode_s1 == pbs_pkg::CMD_ON ||
				mode_s1 == pbs_pkg::CMD_OFF || mode_s1 == pbs_pkg::CMD_FORCE ||
				mode_s1 == pbs_pkg::CMD_REBOOT)) begin
			cmd_d    = pbs_pkg::cmd_t'(mode_s1);
			reboot_d = 1'b0;
			if (mode_s1 == pbs_pkg::CMD_REBOOT) begin
				if (on) begin
					cmd_d    = pbs_pkg::CMD_OFF;
					reboot_d = 1'b1;
				end else begin
					cmd_d    = pbs_pkg::CMD_ON;
				end
			end
			if ((cmd_d == pbs_pkg::CMD_ON) == on) begin
				done_d   = 1'b1;
				succ_d   = 1'b1;
				reboot_d = 1'b0;
			end else begin
				phase_d = (cmd_d == pbs_pkg::CMD_FORCE) ? pbs_pkg::PH_FORCE : pbs_pkg::PH_PRESS;
				seq_d   = '0;
			end
		end

		if (phase_d == pbs_pkg::PH_PRESS) begin
			if (seq_d < timing.press_ticks) begin
				relay_d = 1'b1;
				seq_d   = seq_d + 1'b1;
			end else begin
				phase_d = pbs_pkg::PH_WAIT;
				seq_d   = '0;
			end
		end else if (phase_d == pbs_pkg::PH_FORCE) begin
			if (!on) begin
				phase_d = pbs_pkg::PH_IDLE;
				done_d  = 1'b1;
				succ_d  = 1'b1;
			end else if (seq_d >= timing.force_timeout_ticks) begin
				phase_d = pbs_pkg::PH_IDLE;
				done_d  = 1'b1;
			end else begin
				relay_d = 1'b1;
				seq_d   = seq_d + 1'b1;
			end
		end

		if (phase_d == pbs_pkg::PH_WAIT) begin
			if (cmd_d == pbs_pkg::CMD_ON) begin
				wait_limit = timing.on_timeout_ticks;
			end else if (cmd_d == pbs_pkg::CMD_OFF) begin
				wait_limit = timing.off_timeout_ticks;
			end
			if (on == (cmd_d == pbs_pkg::CMD_ON)) begin
				if (reboot_d && cmd_d == pbs_pkg::CMD_OFF) begin
					reboot_d = 1'b0;
					cmd_d    = pbs_pkg::CMD_ON;
					phase_d  = pbs_pkg::PH_PRESS;
					seq_d    = '0;
					chain    = 1'b1;
				end else begin
					phase_d = pbs_pkg::PH_IDLE;
					done_d  = 1'b1;
					succ_d  = 1'b1;
				end
			end else if (seq_d >= wait_limit) begin
				phase_d  = pbs_pkg::PH_IDLE;
				done_d   = 1'b1;
				reboot_d = 1'b0;
			end else begin
				seq_d = seq_d + 1'b1;
			end
		end

		// Power-on half of a reboot, started in the tick the shutdown completed.
		// The machine is off here, so its wait can only time out or count.
		if (chain) begin
			if (timing.press_ticks != '0) begin
				relay_d = 1'b1;
				seq_d   = pbs_pkg::SEQ_W'(1);
			end else if (timing.on_timeout_ticks == '0) begin
				phase_d = pbs_pkg::PH_IDLE;
				done_d  = 1'b1;
			end else begin
				phase_d = pbs_pkg::PH_WAIT;
				seq_d   = pbs_pkg::SEQ_W'(1);
			end
		end
	end

	// On-time counter
	assign sub_inc = {1'b0, sub_q} + 1'b1;

	always_comb begin
		sub_d    = '0;
		on_sec_d = '0;
		if (on) begin
			on_sec_d = on_sec_q;
			if (sub_inc >= {1'b0, timing.ticks_per_second}) begin
				if (on_sec_q != '1) begin
					on_sec_d = on_sec_q + 1'b1;
				end
			end else begin
				sub_d = sub_inc[pbs_pkg::TPS_W-1:0];
			end
		end
	end

	generate
		if (ON_TIME_BITS > pbs_pkg::OUT_W) begin : g_sat
			assign on_time_sat = (|on_sec_d[ON_TIME_BITS-1:pbs_pkg::OUT_W]) ? '1
				: on_sec_d[pbs_pkg::OUT_W-1:0];
		end else begin : g_ext
			assign on_time_sat = pbs_pkg::OUT_W'(on_sec_d);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pbs_pkg::PH_IDLE;
			cmd_q    <= pbs_pkg::CMD_NONE;
			reboot_q <= 1'b0;
			seq_q    <= '0;
			sub_q    <= '0;
			on_sec_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			reboot_q <= reboot_d;
			seq_q    <= seq_d;
			sub_q    <= sub_d;
			on_sec_q <= on_sec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_q      <= relay_d;
			machine_on_q <= on;
			busy_q       <= (phase_d != pbs_pkg::PH_IDLE);
			done_q       <= done_d;
			succ_q       <= succ_d;
			on_time_q    <= on_time_sat;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.relay_drive     = relay_q;
	assign result.machine_on      = machine_on_q;
	assign result.busy_res        = busy_q;
	assign result.done_res        = done_q;
	assign result.success         = succ_q;
	assign result.on_time_seconds = on_time_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Testbench for power_button_sequencer_top: drives tick requests, predicts every
// result in a scoreboard class and checks each one in order of arrival.
// Depends on pbs_pkg, pbs_chan_if and the RTL of the block.

module testbench;
	import pbs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_TOP = '1;   // highest unused mode code
	localparam int unsigned HOLD_OFF_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] = '{CFG_TICKS_PER_SECOND,
		CFG_PRESS_SECONDS, CFG_SHUTDOWN_TIMEOUT, CFG_FORCE_TIMEOUT, CFG_POWER_ON_TIMEOUT};

	typedef struct packed {
		logic             relay;
		logic             on;
		logic             busy;
		logic             done;
		logic             succ;
		logic [OUT_W-1:0] seconds;
	} outcome_t;

	class relay_sequence_checker;
		logic [TPS_W-1:0] tps;
		logic [SEC_W-1:0] press_s, off_s, forced_s, on_s;
		phase_t           ph;
		cmd_t             active;
		bit               reboot_pend;
		int unsigned      seq_ticks;
		int unsigned      sub_ticks;
		logic [OUT_W-1:0] on_secs;
		outcome_t         outcomes_due[$];
		int               mismatches;

		function new();
			tps = TPS_RST;
			press_s = PRESS_RST;
			off_s = SHUTDOWN_RST;
			forced_s = FORCE_RST;
			on_s = POWER_ON_RST;
			ph = PH_IDLE;
			active = CMD_NONE;
			reboot_pend = 0;
			seq_ticks = 0;
			sub_ticks = 0;
			on_secs = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_TICKS_PER_SECOND: tps = val[TPS_W-1:0];
				CFG_PRESS_SECONDS:    press_s = val[SEC_W-1:0];
				CFG_SHUTDOWN_TIMEOUT: off_s = val[SEC_W-1:0];
				CFG_FORCE_TIMEOUT:    forced_s = val[SEC_W-1:0];
				CFG_POWER_ON_TIMEOUT: on_s = val[SEC_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned press_ticks();
			int unsigned s;
			s = press_s;
			return s * tps;
		endfunction

		function int unsigned limit_for(cmd_t c);
			int unsigned s;
			if (c == CMD_ON)
				s = on_s;
			else if (c == CMD_OFF)
				s = off_s;
			else
				s = forced_s;
			return s * tps;
		endfunction

		function bit busy();
			return ph != PH_IDLE;
		endfunction

		// sense level the running sequence is trying to reach
		function logic goal_level();
			return (active == CMD_ON) ? 1'b0 : 1'b1;
		endfunction

		function void take_tick(logic sense, logic [MODE_W-1:0] mode);
			outcome_t o;
			bit on;
			cmd_t c;
			int guard;
			o = '0;
			on = !sense;
			if (ph == PH_IDLE && mode >= CMD_ON && mode <= CMD_REBOOT) begin
				c = cmd_t'(mode);
				reboot_pend = 0;
				if (c == CMD_REBOOT) begin
					if (on) begin
						c = CMD_OFF;
						reboot_pend = 1;
					end else
						c = CMD_ON;
				end
				active = c;
				if ((c == CMD_ON) == on) begin
					o.done = 1;
					o.succ = 1;
					reboot_pend = 0;
				end else begin
					ph = (c == CMD_FORCE) ? PH_FORCE : PH_PRESS;
					seq_ticks = 0;
				end
			end
			// a tick can fall through press -> wait -> press (reboot) before settling
			for (guard = 0; guard < 4; guard++) begin
				if (ph == PH_PRESS) begin
					if (seq_ticks < press_ticks()) begin
						o.relay = 1;
						seq_ticks++;
						break;
					end
					ph = PH_WAIT;
					seq_ticks = 0;
				end else if (ph == PH_WAIT) begin
					if (on == (active == CMD_ON)) begin
						if (reboot_pend && active == CMD_OFF) begin
							reboot_pend = 0;
							active = CMD_ON;
							ph = PH_PRESS;
							seq_ticks = 0;
							continue;
						end
						ph = PH_IDLE;
						o.done = 1;
						o.succ = 1;
					end else if (seq_ticks >= limit_for(active)) begin
						ph = PH_IDLE;
						o.done = 1;
						reboot_pend = 0;
					end else
						seq_ticks++;
					break;
				end else if (ph == PH_FORCE) begin
					if (!on) begin
						ph = PH_IDLE;
						o.done = 1;
						o.succ = 1;
					end else if (seq_ticks >= limit_for(CMD_FORCE)) begin
						ph = PH_IDLE;
						o.done = 1;
					end else begin
						o.relay = 1;
						seq_ticks++;
					end
					break;
				end else
					break;
			end
			if (on) begin
				sub_ticks++;
				if (sub_ticks >= tps) begin
					sub_ticks = 0;
					if (on_secs != '1)
						on_secs++;
				end
			end else begin
				sub_ticks = 0;
				on_secs = '0;
			end
			o.on = on;
			o.busy = (ph != PH_IDLE);
			o.seconds = on_secs;
			outcomes_due.push_back(o);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void compare_outcome(outcome_t got);
			outcome_t want;
			if (outcomes_due.size() == 0) begin
				flag("result arrived with no request pending");
				return;
			end
			want = outcomes_due.pop_front();
			if (got !== want)
				flag($sformatf({"mismatch: expected relay=%0b on=%0b busy=%0b done=%0b ",
					"success=%0b secs=%0d, got relay=%0b on=%0b busy=%0b done=%0b ",
					"success=%0b secs=%0d"},
					want.relay, want.on, want.busy, want.done, want.succ, want.seconds,
					got.relay, got.on, got.busy, got.done, got.succ, got.seconds));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pbs_item_if   item_ch ();
	pbs_result_if result_ch ();

	power_button_sequencer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	relay_sequence_checker book = new();
	bit          sender_idles;
	bit          receiver_idles;
	int unsigned hold_off;
	int          sent;
	logic        level;   // sense level of the simulated machine

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// result side: random stalls, plus one long hold-off when asked
	initial begin : result_drain
		int stall;
		outcome_t got;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 4) : 0;
			if (hold_off != 0) begin
				stall += hold_off;
				hold_off = 0;
			end
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (result_ch.valid !== 1'b1) @(posedge clk);
			got.relay = result_ch.relay_drive;
			got.on = result_ch.machine_on;
			got.busy = result_ch.busy_res;
			got.done = result_ch.done_res;
			got.succ = result_ch.success;
			got.seconds = result_ch.on_time_seconds;
			book.compare_outcome(got);
		end
	end

	task automatic send_tick(input logic s, input logic [MODE_W-1:0] m);
		int gap;
		gap = sender_idles ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.sense_level <= s;
		item_ch.mode <= m;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		book.take_tick(s, m);
		sent++;
	endtask

	// machine mostly follows the running sequence, with occasional noise
	task automatic step_machine(input logic [MODE_W-1:0] m);
		if (book.busy() && $urandom_range(0, 3) == 0)
			level = book.goal_level();
		else if ($urandom_range(0, 19) == 0)
			level = !level;
		send_tick(level, m);
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (book.outcomes_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input int unsigned vals[5]);
		int i;
		for (i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_wdata <= CFG_DATA_W'(vals[i]);
			book.set_reg(REG_ORDER[i], CFG_DATA_W'(vals[i]));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned vals[5], input int items, input bit idles,
		input bit squeeze);
		int start;
		int r;
		int len;
		bit squeezed;
		logic [MODE_W-1:0] m;
		settle();
		apply_settings(vals);
		sender_idles = idles;
		receiver_idles = idles;
		start = sent;
		squeezed = 0;
		while (sent - start < items) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				m = MODE_W'($urandom_range(CMD_ON, CMD_REBOOT));
			else if (r == 7)
				m = MODE_W'($urandom_range(CMD_REBOOT + 1, MODE_TOP));
			else
				m = CMD_NONE;
			step_machine(m);
			len = $urandom_range(0, 12);
			repeat (len)
				step_machine(($urandom_range(0, 9) == 0) ?
					MODE_W'($urandom_range(0, MODE_TOP)) : CMD_NONE);
			if (squeeze && !squeezed && sent - start > items / 2) begin
				hold_off = HOLD_OFF_CYCLES;
				squeezed = 1;
			end
		end
		while (book.busy()) step_machine(CMD_NONE);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TICKS_PER_SECOND;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.sense_level <= 1'b1;
		item_ch.mode <= CMD_NONE;
		level = 1'b1;
		sender_idles = 0;
		receiver_idles = 0;
		hold_off = 0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset timing is long: only commands whose target already holds
		send_tick(1'b0, CMD_ON);
		send_tick(1'b0, CMD_NONE);
		send_tick(1'b1, CMD_OFF);
		send_tick(1'b1, CMD_FORCE);
		send_tick(1'b1, MODE_TOP);
		settle();

		// two ticks per second: press 2, shutdown wait 4, force 2, power-on wait 4
		apply_settings('{2, 1, 2, 1, 2});
		send_tick(1'b1, CMD_ON);
		send_tick(1'b1, CMD_OFF);              // ignored while busy
		send_tick(1'b0, CMD_NONE);
		send_tick(1'b0, CMD_OFF);              // soft shutdown that times out
		repeat (7) send_tick(1'b0, CMD_NONE);
		send_tick(1'b0, CMD_FORCE);
		send_tick(1'b1, CMD_NONE);
		send_tick(1'b0, CMD_FORCE);            // forced hold runs out
		repeat (2) send_tick(1'b0, CMD_NONE);
		send_tick(1'b0, CMD_REBOOT);           // shutdown then power on
		send_tick(1'b1, CMD_NONE);
		repeat (2) send_tick(1'b1, CMD_NONE);
		send_tick(1'b0, CMD_NONE);
		send_tick(1'b1, CMD_REBOOT);           // off: plain power on, never answered
		repeat (6) send_tick(1'b1, CMD_NONE);
		level = 1'b1;
		while (book.busy()) step_machine(CMD_NONE);

		run_phase('{1, 1, 2, 2, 2}, 130, 1'b1, 1'b0);
		run_phase('{2, 0, 3, 1, 3}, 130, 1'b0, 1'b1);
		run_phase('{3, 1, 1, 2, 1}, 130, 1'b1, 1'b0);
		run_phase('{0, 255, 255, 255, 255}, 130, 1'b0, 1'b0);
		run_phase('{1, 0, 0, 0, 0}, 130, 1'b1, 1'b1);
		run_phase('{65535, 0, 0, 0, 0}, 120, 1'b0, 1'b0);
		run_phase('{1, 255, 2, 255, 3}, 60, 1'b1, 1'b0);
		run_phase('{4, 2, 5, 3, 5}, 130, 1'b0, 1'b0);
		settle();

		if (book.mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
